/* hw/rtl/scsmj_pkg.sv */
// ----------------------------------------------------------------------------
// scsmj_pkg
// Shared types and constants for the sorted count stream merge join.
// ----------------------------------------------------------------------------
package scsmj_pkg;

  localparam int unsigned KEY_W        = 64;
  localparam int unsigned KEY_BITS_DEF = 64;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned MODE_W       = 2;

  // Scale factor of the ratio mode and the width it adds to the dividend
  localparam int unsigned SCALE_W      = 10;
  localparam logic [SCALE_W-1:0] RATIO_SCALE = SCALE_W'(1000);
  localparam int unsigned DIVIDEND_W   = COUNT_W + SCALE_W;

  // One quotient bit per divider stage, plus the entry stage
  localparam int unsigned DIV_STEPS    = COUNT_W;
  localparam int unsigned DIV_LAT      = DIV_STEPS + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUB = 2'd0,
    MODE_ABS = 2'd1,
    MODE_DIV = 2'd2
  } mode_e;

  // Request into the pipelined divider
  typedef struct packed {
    logic                  vld;
    logic [DIVIDEND_W-1:0] num;
    logic [COUNT_W-1:0]    den;
  } div_req_t;

  // Result out of the pipelined divider
  typedef struct packed {
    logic               vld;
    logic [COUNT_W-1:0] quo;
  } div_rsp_t;

endpackage

/* hw/rtl/scsmj_div.sv */
// ----------------------------------------------------------------------------
// scsmj_div
// Pipelined restoring divider, one quotient bit per stage, saturating at
// the all-ones count.
// ----------------------------------------------------------------------------
module scsmj_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scsmj_pkg::div_req_t req_i,
  output scsmj_pkg::div_rsp_t rsp_o
);
  import scsmj_pkg::*;

  logic               vld_q [DIV_STEPS+1];
  logic               sat_q [DIV_STEPS+1];
  logic [COUNT_W-1:0] rem_q [DIV_STEPS+1];
  logic [COUNT_W-1:0] lq_q  [DIV_STEPS+1];
  logic [COUNT_W-1:0] den_q [DIV_STEPS+1];

  // Entry stage: the quotient overflows exactly when the upper dividend part
  // is not below the divisor; in every case it seeds the partial remainder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= req_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= COUNT_W'(req_i.num[DIVIDEND_W-1:COUNT_W]);
    lq_q[0]  <= req_i.num[COUNT_W-1:0];
    den_q[0] <= req_i.den;
    sat_q[0] <= (COUNT_W'(req_i.num[DIVIDEND_W-1:COUNT_W]) >= req_i.den);
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic [COUNT_W:0] trial;
    logic [COUNT_W:0] diff;
    logic             ge;

    assign trial = {rem_q[g], lq_q[g][COUNT_W-1]};
    assign diff  = trial - {1'b0, den_q[g]};
    assign ge    = (trial >= {1'b0, den_q[g]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    // Shift one dividend bit in, one quotient bit out
    always_ff @(posedge clk_i) begin
      rem_q[g+1] <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      lq_q[g+1]  <= {lq_q[g][COUNT_W-2:0], ge};
      den_q[g+1] <= den_q[g];
      sat_q[g+1] <= sat_q[g];
    end
  end

  assign rsp_o.vld = vld_q[DIV_STEPS];
  assign rsp_o.quo = sat_q[DIV_STEPS] ? {COUNT_W{1'b1}} : lq_q[DIV_STEPS];

endmodule

/* hw/rtl/sorted_count_stream_merge_join.sv */
// ----------------------------------------------------------------------------
// sorted_count_stream_merge_join
// Merge join of two key-sorted (key, count) stream heads: subtract, absolute
// difference or scaled ratio per key, with pop flags for each stream.
// ----------------------------------------------------------------------------
// Pipeline: one compare/multiply stage, 33 divider stages and one output
//   register carry each start beat to the result strobe.
// Throughput: one head pair per cycle; busy_o is never raised, and the
//   33-stage divider is fully pipelined so it never holds the input off.
// Reset: clears the mode register to subtract and drops all beats in flight.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_count_stream_merge_join #(
  parameter int unsigned KEY_BITS = scsmj_pkg::KEY_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [scsmj_pkg::MODE_W-1:0]     cfg_wdata_i,
  // command
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             a_valid_i,
  input  logic [scsmj_pkg::KEY_W-1:0]      a_key_i,
  input  logic [scsmj_pkg::COUNT_W-1:0]    a_count_i,
  input  logic                             b_valid_i,
  input  logic [scsmj_pkg::KEY_W-1:0]      b_key_i,
  input  logic [scsmj_pkg::COUNT_W-1:0]    b_count_i,
  // result
  output logic                             res_valid_o,
  output logic                             emit_o,
  output logic [scsmj_pkg::KEY_W-1:0]      out_key_o,
  output logic [scsmj_pkg::COUNT_W-1:0]    out_count_o,
  output logic                             pop_a_o,
  output logic                             pop_b_o,
  output logic                             done_res_o
);
  import scsmj_pkg::*;

  // Per-beat control that rides alongside the divider
  typedef struct packed {
    logic               vld;
    logic               emit;
    logic               div;
    logic               pop_a;
    logic               pop_b;
    logic               done;
    logic [COUNT_W-1:0] cnt;
  } side_t;

  // --------------------------------------------------------------------------
  // Mode register
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SUB;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Every stage advances every cycle, so the command port is always open.
  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // Stage A: effective heads, key compare, record choice, ratio numerator
  // --------------------------------------------------------------------------
  logic [KEY_BITS-1:0] ka, kb, key_d;
  logic [COUNT_W-1:0]  ca, cb;
  logic                keq, klt;
  side_t               side_d;

  always_comb begin
    ka = a_key_i[KEY_BITS-1:0];
    kb = b_key_i[KEY_BITS-1:0];
    ca = a_count_i;
    cb = b_count_i;
    // An exhausted stream takes the other head's key with a zero count
    if (!a_valid_i) begin
      ka = kb;
      ca = '0;
    end
    if (!b_valid_i) begin
      kb = ka;
      cb = '0;
    end
    keq = (ka == kb);
    klt = (ka < kb);

    side_d     = '0;
    side_d.vld = start_i;
    key_d      = ka;

    if (!a_valid_i && !b_valid_i) begin
      side_d.done = 1'b1;
    end else begin
      case (mode_q)
        MODE_SUB: begin
          if (keq) begin
            side_d.pop_a = a_valid_i;
            side_d.pop_b = b_valid_i;
            side_d.emit  = 1'b1;
            side_d.cnt   = (ca > cb) ? ca - cb : '0;
          end else if (klt) begin
            side_d.pop_a = 1'b1;
            side_d.emit  = 1'b1;
            side_d.cnt   = ca;
          end else begin
            // key only in B: drop it
            side_d.pop_b = 1'b1;
          end
        end
        MODE_ABS: begin
          if (keq) begin
            side_d.pop_a = a_valid_i;
            side_d.pop_b = b_valid_i;
            side_d.emit  = 1'b1;
            side_d.cnt   = (ca > cb) ? ca - cb : cb - ca;
          end else if (klt) begin
            side_d.pop_a = 1'b1;
            side_d.emit  = 1'b1;
            side_d.cnt   = ca;
          end else begin
            side_d.pop_b = 1'b1;
            side_d.emit  = 1'b1;
            side_d.cnt   = cb;
            key_d        = kb;
          end
        end
        MODE_DIV: begin
          if (keq) begin
            side_d.pop_a = a_valid_i;
            side_d.pop_b = b_valid_i;
            // ratio only where both counts are nonzero
            if ((ca != '0) && (cb != '0)) begin
              side_d.emit = 1'b1;
              side_d.div  = 1'b1;
            end
          end else if (klt) begin
            side_d.pop_a = 1'b1;
          end else begin
            side_d.pop_b = 1'b1;
          end
        end
        default: begin
          // unused mode: stall the join, emit and pop nothing
        end
      endcase
    end
  end

  side_t                 sa_side_q;
  logic [KEY_BITS-1:0]   sa_key_q;
  logic [DIVIDEND_W-1:0] sa_num_q;
  logic [COUNT_W-1:0]    sa_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_side_q <= '0;
    end else begin
      sa_side_q <= side_d;
    end
  end

  // Hold the scaled numerator and divisor for the divider entry
  always_ff @(posedge clk_i) begin
    sa_key_q <= key_d;
    sa_num_q <= DIVIDEND_W'(ca) * DIVIDEND_W'(RATIO_SCALE);
    sa_den_q <= cb;
  end

  // --------------------------------------------------------------------------
  // Divider and the matching delay line for the rest of the beat
  // --------------------------------------------------------------------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.vld = sa_side_q.vld & sa_side_q.div;
  assign div_req.num = sa_num_q;
  assign div_req.den = sa_den_q;

  scsmj_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  side_t               dl_side_q [DIV_LAT];
  logic [KEY_BITS-1:0] dl_key_q  [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl_side_q[i] <= '0;
      end
    end else begin
      dl_side_q[0] <= sa_side_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_side_q[i] <= dl_side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl_key_q[0] <= sa_key_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      dl_key_q[i] <= dl_key_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick the quotient for ratio beats, zero unused fields
  // --------------------------------------------------------------------------
  side_t               last_side;
  logic [KEY_BITS-1:0] last_key;
  logic [COUNT_W-1:0]  cnt_sel;

  assign last_side = dl_side_q[DIV_LAT-1];
  assign last_key  = dl_key_q[DIV_LAT-1];
  assign cnt_sel   = (last_side.div && div_rsp.vld) ? div_rsp.quo : last_side.cnt;

  logic               res_valid_q, emit_q, pop_a_q, pop_b_q, done_q;
  logic [KEY_W-1:0]   key_q;
  logic [COUNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= last_side.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_q  <= last_side.emit;
    pop_a_q <= last_side.pop_a;
    pop_b_q <= last_side.pop_b;
    done_q  <= last_side.done;
    key_q   <= last_side.emit ? KEY_W'(last_key) : '0;
    cnt_q   <= last_side.emit ? cnt_sel : '0;
  end

  assign res_valid_o = res_valid_q;
  assign emit_o      = emit_q;
  assign out_key_o   = key_q;
  assign out_count_o = cnt_q;
  assign pop_a_o     = pop_a_q;
  assign pop_b_o     = pop_b_q;
  assign done_res_o  = done_q;

endmodule

/* tb/sorted_count_stream_merge_join_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_count_stream_merge_join_tb
// Self-checking bench for the merge join: drives head pairs as start beats,
// predicts each result in a scoreboard and compares every strobed result.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                            a_valid;
  logic [scsmj_pkg::KEY_W-1:0]     a_key;
  logic [scsmj_pkg::COUNT_W-1:0]   a_count;
  logic                            b_valid;
  logic [scsmj_pkg::KEY_W-1:0]     b_key;
  logic [scsmj_pkg::COUNT_W-1:0]   b_count;
} head_pair_t;

typedef struct packed {
  logic                            emit;
  logic [scsmj_pkg::KEY_W-1:0]     out_key;
  logic [scsmj_pkg::COUNT_W-1:0]   out_count;
  logic                            pop_a;
  logic                            pop_b;
  logic                            done_res;
} join_res_t;

class join_scoreboard;
  localparam int unsigned         KEY_BITS_USED = scsmj_pkg::KEY_BITS_DEF;
  localparam logic [63:0]         KEY_MASK      = {64{1'b1}} >> (64 - KEY_BITS_USED);
  localparam logic [63:0]         RATIO_FACTOR  = 64'd1000;
  localparam logic [31:0]         COUNT_SAT     = 32'hFFFF_FFFF;

  logic [scsmj_pkg::MODE_W-1:0] mode;
  join_res_t                    expected_q[$];
  int                           mismatches;

  function new();
    mode       = scsmj_pkg::MODE_SUB;
    mismatches = 0;
  endfunction

  // Merge join step for one head pair under the current mode
  function join_res_t join_step(head_pair_t hp);
    join_res_t   r;
    logic [63:0] ka, kb, quot;
    logic [31:0] ca, cb;
    r  = '0;
    ka = hp.a_key & KEY_MASK;
    kb = hp.b_key & KEY_MASK;
    ca = hp.a_count;
    cb = hp.b_count;
    if (!hp.a_valid && !hp.b_valid) begin
      r.done_res = 1'b1;
    end else if (mode <= scsmj_pkg::MODE_DIV) begin
      // An exhausted stream mirrors the other head with a zero count
      if (!hp.a_valid) begin
        ka = kb;
        ca = '0;
      end
      if (!hp.b_valid) begin
        kb = ka;
        cb = '0;
      end
      if (ka == kb) begin
        r.pop_a = hp.a_valid;
        r.pop_b = hp.b_valid;
        case (mode)
          scsmj_pkg::MODE_SUB: begin
            r.emit      = 1'b1;
            r.out_key   = ka;
            r.out_count = (ca > cb) ? ca - cb : '0;
          end
          scsmj_pkg::MODE_ABS: begin
            r.emit      = 1'b1;
            r.out_key   = ka;
            r.out_count = (ca > cb) ? ca - cb : cb - ca;
          end
          default: begin
            if (ca != 0 && cb != 0) begin
              quot        = (64'(ca) * RATIO_FACTOR) / 64'(cb);
              r.emit      = 1'b1;
              r.out_key   = ka;
              r.out_count = (quot > 64'(COUNT_SAT)) ? COUNT_SAT : quot[31:0];
            end
          end
        endcase
      end else if (ka < kb) begin
        r.pop_a = 1'b1;
        if (mode != scsmj_pkg::MODE_DIV) begin
          r.emit      = 1'b1;
          r.out_key   = ka;
          r.out_count = ca;
        end
      end else begin
        r.pop_b = 1'b1;
        if (mode == scsmj_pkg::MODE_ABS) begin
          r.emit      = 1'b1;
          r.out_key   = kb;
          r.out_count = cb;
        end
      end
    end
    return r;
  endfunction

  function void note_beat(head_pair_t hp);
    expected_q.push_back(join_step(hp));
  endfunction

  function void check_result(join_res_t got);
    join_res_t want;
    if (expected_q.size() == 0) begin
      $error("result with no beat outstanding: emit %0b key %h count %h",
             got.emit, got.out_key, got.out_count);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (got.emit !== want.emit) begin
      $error("emit: expected %0b, got %0b", want.emit, got.emit);
      mismatches++;
    end
    if (got.out_key !== want.out_key) begin
      $error("out_key: expected %h, got %h", want.out_key, got.out_key);
      mismatches++;
    end
    if (got.out_count !== want.out_count) begin
      $error("out_count: expected %h, got %h", want.out_count, got.out_count);
      mismatches++;
    end
    if (got.pop_a !== want.pop_a) begin
      $error("pop_a: expected %0b, got %0b", want.pop_a, got.pop_a);
      mismatches++;
    end
    if (got.pop_b !== want.pop_b) begin
      $error("pop_b: expected %0b, got %0b", want.pop_b, got.pop_b);
      mismatches++;
    end
    if (got.done_res !== want.done_res) begin
      $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module sorted_count_stream_merge_join_tb;
  import scsmj_pkg::*;

  localparam logic [MODE_W-1:0]  MODE_STALL     = 2'd3;  // unused code: join holds
  localparam logic [KEY_W-1:0]   KEY_ALL        = '1;
  localparam logic [COUNT_W-1:0] COUNT_ALL      = '1;
  localparam int                 PHASE_BEATS    = 108;
  localparam int                 WALK_MAX       = 12;
  localparam int                 TAIL_CYCLES    = DIV_LAT + 8;
  localparam int                 TIMEOUT_NS     = 2_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [MODE_W-1:0]   cfg_wdata_i;
  logic                start_i;
  logic                busy_o;
  logic                a_valid_i;
  logic [KEY_W-1:0]    a_key_i;
  logic [COUNT_W-1:0]  a_count_i;
  logic                b_valid_i;
  logic [KEY_W-1:0]    b_key_i;
  logic [COUNT_W-1:0]  b_count_i;
  logic                res_valid_o;
  logic                emit_o;
  logic [KEY_W-1:0]    out_key_o;
  logic [COUNT_W-1:0]  out_count_o;
  logic                pop_a_o;
  logic                pop_b_o;
  logic                done_res_o;

  join_scoreboard sb = new();

  // Sender idle percentage of the current phase
  int sender_idle_pct;

  // Sorted stream walk: remaining records and current heads of A and B
  int                  walk_a_left, walk_b_left;
  logic [KEY_W-1:0]    walk_a_key, walk_b_key;
  logic [COUNT_W-1:0]  walk_a_cnt, walk_b_cnt;

  sorted_count_stream_merge_join dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .a_valid_i   (a_valid_i),
    .a_key_i     (a_key_i),
    .a_count_i   (a_count_i),
    .b_valid_i   (b_valid_i),
    .b_key_i     (b_key_i),
    .b_count_i   (b_count_i),
    .res_valid_o (res_valid_o),
    .emit_o      (emit_o),
    .out_key_o   (out_key_o),
    .out_count_o (out_count_o),
    .pop_a_o     (pop_a_o),
    .pop_b_o     (pop_b_o),
    .done_res_o  (done_res_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watch the ports at every rising edge: track mode writes, note accepted
  // beats and check each strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    join_res_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        sb.mode = cfg_wdata_i;
      end
      if (start_i && !busy_o) begin
        sb.note_beat('{a_valid: a_valid_i, a_key: a_key_i, a_count: a_count_i,
                       b_valid: b_valid_i, b_key: b_key_i, b_count: b_count_i});
      end
      if (res_valid_o) begin
        got.emit      = emit_o;
        got.out_key   = out_key_o;
        got.out_count = out_count_o;
        got.pop_a     = pop_a_o;
        got.pop_b     = pop_b_o;
        got.done_res  = done_res_o;
        sb.check_result(got);
      end
    end
  end

  // Hard stop in case the block hangs or drops results
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic head_pair_t mk_pair(logic av, logic [KEY_W-1:0] ak,
                                         logic [COUNT_W-1:0] ac, logic bv,
                                         logic [KEY_W-1:0] bk,
                                         logic [COUNT_W-1:0] bc);
    head_pair_t hp;
    hp.a_valid = av;
    hp.a_key   = ak;
    hp.a_count = ac;
    hp.b_valid = bv;
    hp.b_key   = bk;
    hp.b_count = bc;
    return hp;
  endfunction

  // Keys lean toward the ends of the range and small values
  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(4))
      0:       return '0;
      1:       return KEY_ALL;
      2:       return KEY_W'($urandom_range(15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 32'd1;
      2:       return COUNT_ALL;
      3:       return COUNT_W'($urandom_range(2000));
      default: return $urandom;
    endcase
  endfunction

  // Unrelated head pair; keys collide often enough to hit the equal path
  function automatic head_pair_t noise_pair();
    logic [KEY_W-1:0] ak;
    ak = rand_key();
    return mk_pair($urandom_range(3) != 0, ak, rand_count(),
                   $urandom_range(3) != 0,
                   ($urandom_range(9) < 3) ? ak : rand_key(), rand_count());
  endfunction

  // Open a fresh pair of sorted streams near a random base key
  task automatic walk_open();
    logic [KEY_W-1:0] base;
    case ($urandom_range(3))
      0:       base = '0;
      1:       base = KEY_ALL - 64;
      default: base = {$urandom, $urandom};
    endcase
    if (base > KEY_ALL - 64) begin
      base = KEY_ALL - 64;
    end
    walk_a_left = $urandom_range(WALK_MAX);
    walk_b_left = $urandom_range(WALK_MAX);
    walk_a_key  = base + $urandom_range(2);
    walk_b_key  = base + $urandom_range(2);
    walk_a_cnt  = rand_count();
    walk_b_cnt  = rand_count();
  endtask

  // Present the current stream heads; an exhausted side shows garbage fields
  function automatic head_pair_t walk_heads();
    return mk_pair(walk_a_left > 0, (walk_a_left > 0) ? walk_a_key : rand_key(),
                   (walk_a_left > 0) ? walk_a_cnt : rand_count(),
                   walk_b_left > 0, (walk_b_left > 0) ? walk_b_key : rand_key(),
                   (walk_b_left > 0) ? walk_b_cnt : rand_count());
  endfunction

  // Advance the streams as the block's pops will ask; restart when both end
  task automatic walk_advance(head_pair_t hp);
    join_res_t r;
    r = sb.join_step(hp);
    if (r.pop_a) begin
      walk_a_left--;
      walk_a_key += $urandom_range(1, 3);
      walk_a_cnt  = rand_count();
    end
    if (r.pop_b) begin
      walk_b_left--;
      walk_b_key += $urandom_range(1, 3);
      walk_b_cnt  = rand_count();
    end
    if (r.done_res) begin
      walk_open();
    end
  endtask

  // Drive one beat from a falling edge, hold until accepted, then maybe idle.
  // Start stays high on return when no idle was drawn, so back-to-back beats see no gap.
  task automatic drive_beat(head_pair_t hp);
    start_i   <= 1'b1;
    a_valid_i <= hp.a_valid;
    a_key_i   <= hp.a_key;
    a_count_i <= hp.a_count;
    b_valid_i <= hp.b_valid;
    b_key_i   <= hp.b_key;
    b_count_i <= hp.b_count;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Drop start and wait until every predicted result has been checked
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Write the mode register while the block is idle
  task automatic write_mode(logic [MODE_W-1:0] m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    head_pair_t         directed[8];
    head_pair_t         hp;
    bit                 from_walk;
    logic [MODE_W-1:0]  phase_mode;

    // Hold every input at a known value from time zero
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    start_i         = 1'b0;
    a_valid_i       = 1'b0;
    a_key_i         = '0;
    a_count_i       = '0;
    b_valid_i       = 1'b0;
    b_key_i         = '0;
    b_count_i       = '0;
    sender_idle_pct = 0;

    // Corner pairs: both exhausted, ratio overflow at the top key, zero
    // counts, A behind, A ahead, and each stream exhausted on its own
    directed[0] = mk_pair(1'b0, KEY_ALL, COUNT_ALL, 1'b0, '0, 32'd1);
    directed[1] = mk_pair(1'b1, KEY_ALL, COUNT_ALL, 1'b1, KEY_ALL, 32'd1);
    directed[2] = mk_pair(1'b1, '0, '0, 1'b1, '0, COUNT_ALL);
    directed[3] = mk_pair(1'b1, 64'h5, 32'd7, 1'b1, 64'h5, '0);
    directed[4] = mk_pair(1'b1, '0, COUNT_ALL, 1'b1, KEY_ALL, 32'd3);
    directed[5] = mk_pair(1'b1, KEY_ALL, 32'd9, 1'b1, '0, COUNT_ALL);
    directed[6] = mk_pair(1'b0, 64'hDEAD_BEEF_0123_4567, 32'd11,
                          1'b1, 64'h8000_0000_0000_0000, 32'd42);
    directed[7] = mk_pair(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 32'd1000,
                          1'b0, 64'h0123, 32'd5);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: full corner set in sub (reset value), abs and divide,
    // then a short check that the unused mode holds the join
    foreach (directed[i]) drive_beat(directed[i]);
    write_mode(MODE_ABS);
    foreach (directed[i]) drive_beat(directed[i]);
    write_mode(MODE_DIV);
    foreach (directed[i]) drive_beat(directed[i]);
    write_mode(MODE_STALL);
    drive_beat(directed[0]);
    drive_beat(directed[1]);

    // Random part: three idle profiles, each sweeping all four mode codes in
    // a rotated order. Outside the unused mode code most beats follow real sorted
    // streams so the join walks through long sequences; the rest are noise.
    for (int prof = 0; prof < 3; prof++) begin
      for (int m = 0; m < 4; m++) begin
        phase_mode = MODE_W'((m + prof) % 4);
        write_mode(phase_mode);
        sender_idle_pct = (prof == 0) ? 0 : ((prof == 1) ? 80 : 20);
        walk_open();
        for (int n = 0; n < PHASE_BEATS; n++) begin
          from_walk = (phase_mode != MODE_STALL) && ($urandom_range(99) < 75);
          hp = from_walk ? walk_heads() : noise_pair();
          drive_beat(hp);
          if (from_walk) begin
            walk_advance(hp);
          end
        end
        sender_idle_pct = 0;
      end
    end

    // Let the pipeline empty, then give stray strobes a chance to show up
    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (sb.pending() != 0) begin
      $error("%0d predicted results never arrived", sb.pending());
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sorted_count_stream_merge_join.f */
hw/rtl/scsmj_pkg.sv
hw/rtl/scsmj_div.sv
hw/rtl/sorted_count_stream_merge_join.sv
tb/sorted_count_stream_merge_join_tb.sv
